// File: hdl/sph_density_force_accumulator_defines.svh
// Assertion macros used by the checker file of the accumulator.
`ifndef SPH_DENSITY_FORCE_ACCUMULATOR_DEFINES_SVH
`define SPH_DENSITY_FORCE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define SDFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdfa check failed");

// Next-cycle implication, clocked on clk, disabled in reset.
`define SDFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdfa check failed");

`endif

// File: hdl/sdfa_pkg.sv
// Shared types and constants of the SPH density and force accumulator.
package sdfa_pkg;

  localparam int TABLE_BITS    = 10;
  localparam int TABLE_SIZE    = 1 << TABLE_BITS;
  localparam int POS_FRAC_BITS = 6;

  localparam int OPW  = 64;
  localparam int CNTW = 7;
  localparam int SW   = 18;

  localparam logic [1:0] ALU_MUL  = 2'd0;
  localparam logic [1:0] ALU_DIV  = 2'd1;
  localparam logic [1:0] ALU_SQRT = 2'd2;

  localparam logic [2:0] CFG_INV_H  = 3'd0;
  localparam logic [2:0] CFG_KSCALE = 3'd1;
  localparam logic [2:0] CFG_GSCALE = 3'd2;
  localparam logic [2:0] CFG_REST   = 3'd3;
  localparam logic [2:0] CFG_GAIN   = 3'd4;

  typedef struct packed {
    logic            go;
    logic [1:0]      op;
    logic [OPW-1:0]  a;
    logic [OPW-1:0]  b;
    logic [CNTW-1:0] n;
  } alu_req_t;

  typedef struct packed {
    logic           done;
    logic [OPW-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [SW-1:0] ks;
    logic [SW-1:0] gs;
  } tbl_rd_t;

endpackage

// File: hdl/sdfa_in_if.sv
// Pair input channel of the accumulator.
interface sdfa_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] center_z;
  logic [23:0] center_density;
  logic [15:0] neighbor_x;
  logic [15:0] neighbor_y;
  logic [15:0] neighbor_z;
  logic [23:0] neighbor_density;
  logic        last_pair;

  modport source (output valid, func, center_x, center_y, center_z, center_density,
                  neighbor_x, neighbor_y, neighbor_z, neighbor_density, last_pair,
                  input ready);
  modport sink (input valid, func, center_x, center_y, center_z, center_density,
                neighbor_x, neighbor_y, neighbor_z, neighbor_density, last_pair,
                output ready);
endinterface

// File: hdl/sdfa_out_if.sv
// Result output channel of the accumulator.
interface sdfa_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [23:0] density_out;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic        div_fault;

  modport source (output valid, kind, density_out, vel_x, vel_y, vel_z, div_fault,
                  input ready);
  modport sink (input valid, kind, density_out, vel_x, vel_y, vel_z, div_fault,
                output ready);
endinterface

// File: hdl/sph_density_force_accumulator.sv
// Top level of the SPH density and pressure-force accumulator.
// Each input transaction is one (centre, neighbour) pair; the pair's kernel
// term (func 0) or pressure-gradient term (func 1) is added to the running sum,
// and a pair marked last_pair produces one result transaction and clears the
// sums. After reset the block builds its kernel and gradient tables, one entry
// at a time, and in_ready stays low until that sweep ends; config
// writes are taken at any time. All arithmetic runs through one shared unit
// that multiplies 16 bits per cycle and divides or takes a root one bit per
// cycle. A force pair needs a 25-bit root, then per axis a 40-bit and a 60-bit
// divide; the last pair of a force group adds gain scaling on each axis. A
// finished result sits in the output register while the next pair is accepted;
// a second result waits in the sequencer, with in_ready low, until the sink
// takes the first.
module sph_density_force_accumulator (
  input  logic              clk,
  input  logic              rst_n,
  sdfa_in_if.sink           in_ch,
  sdfa_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  localparam int OPW       = sdfa_pkg::OPW;
  localparam int TB        = sdfa_pkg::TABLE_BITS;
  localparam int IDX_SHIFT = sdfa_pkg::POS_FRAC_BITS + 24 - TB;

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_TRD   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic [3:0] SP_SQ   = 4'd0;
  localparam logic [3:0] SP_SQRT = 4'd1;
  localparam logic [3:0] SP_IDX  = 4'd2;
  localparam logic [3:0] SP_KERN = 4'd3;
  localparam logic [3:0] SP_GRAD = 4'd4;
  localparam logic [3:0] SP_U    = 4'd5;
  localparam logic [3:0] SP_GU   = 4'd6;
  localparam logic [3:0] SP_PT   = 4'd7;
  localparam logic [3:0] SP_T    = 4'd8;
  localparam logic [3:0] SP_VEL  = 4'd9;

  localparam logic signed [47:0] FSUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] FSUM_MIN = {1'b1, {47{1'b0}}};

  // configuration
  logic [15:0] inv_h_r;
  logic [31:0] kscale_r;
  logic [31:0] gscale_r;
  logic [23:0] rest_r;
  logic [7:0]  gain_r;

  // sequencer
  logic [2:0] state_r;
  logic [3:0] stp_r;
  logic [1:0] ax_r;

  // latched pair
  logic        func_r;
  logic        last_r;
  logic [15:0] ad_r [3];
  logic [2:0]  dneg_r;
  logic [24:0] aps_r;
  logic        psneg_r;
  logic        psz_r;
  logic [24:0] den_r;

  // intermediates
  logic [33:0]   d2_r;
  logic [24:0]   r_r;
  logic [TB-1:0] idx_r;
  logic [33:0]   g_r;
  logic [16:0]   u_r;
  logic [34:0]   gu_r;
  logic [59:0]   p_r;
  logic [31:0]   vel_r [3];

  // sums
  logic [31:0]        dsum_r;
  logic signed [47:0] fsum_r [3];
  logic               fault_r;

  // output register
  logic        out_valid_r;
  logic        kind_r;
  logic [23:0] dens_o_r;
  logic [31:0] vel_o_r [3];
  logic        flt_o_r;

  sdfa_pkg::alu_req_t alu_req;
  sdfa_pkg::alu_rsp_t alu_rsp;
  sdfa_pkg::tbl_rd_t  tbl_rd;
  logic               tbl_busy;

  sdfa_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  sdfa_tables u_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (idx_r),
    .busy  (tbl_busy),
    .rd    (tbl_rd)
  );

  // input pair decode
  logic signed [16:0] dx, dy, dz;
  logic signed [26:0] ps;
  logic [26:0]        aps_full;
  logic               accept;

  always_comb begin
    dx       = $signed({1'b0, in_ch.center_x}) - $signed({1'b0, in_ch.neighbor_x});
    dy       = $signed({1'b0, in_ch.center_y}) - $signed({1'b0, in_ch.neighbor_y});
    dz       = $signed({1'b0, in_ch.center_z}) - $signed({1'b0, in_ch.neighbor_z});
    ps       = $signed({3'b000, in_ch.center_density}) +
               $signed({3'b000, in_ch.neighbor_density}) -
               $signed({2'b00, rest_r, 1'b0});
    aps_full = ps[26] ? 27'(-ps) : 27'(ps);
    accept   = in_ch.valid && (state_r == ST_IDLE);
  end

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic [16:0] t;
    t = v[16] ? 17'(-v) : 17'(v);
    return t[15:0];
  endfunction

  // axis-selected operands
  logic [47:0] fmag;
  logic        vneg;
  always_comb begin
    vneg = fsum_r[ax_r][47];
    fmag = vneg ? 48'(-fsum_r[ax_r]) : 48'(fsum_r[ax_r]);
  end

  // drive the shared unit for the current step
  always_comb begin
    alu_req.go = (state_r == ST_ISSUE);
    alu_req.op = sdfa_pkg::ALU_MUL;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.n  = '0;
    unique case (stp_r)
      SP_SQ: begin
        alu_req.a = OPW'(ad_r[ax_r]);
        alu_req.b = OPW'(ad_r[ax_r]);
      end
      SP_SQRT: begin
        alu_req.op = sdfa_pkg::ALU_SQRT;
        alu_req.a  = OPW'(d2_r) << 16;
        alu_req.n  = 7'd25;
      end
      SP_IDX: begin
        alu_req.a = OPW'(r_r);
        alu_req.b = OPW'(inv_h_r);
      end
      SP_KERN: begin
        alu_req.a = OPW'(kscale_r);
        alu_req.b = OPW'(tbl_rd.ks);
      end
      SP_GRAD: begin
        alu_req.a = OPW'(gscale_r);
        alu_req.b = OPW'(tbl_rd.gs);
      end
      SP_U: begin
        alu_req.op = sdfa_pkg::ALU_DIV;
        alu_req.a  = OPW'(ad_r[ax_r]) << 24;
        alu_req.b  = OPW'(r_r);
        alu_req.n  = 7'd40;
      end
      SP_GU: begin
        alu_req.a = OPW'(g_r);
        alu_req.b = OPW'(u_r);
      end
      SP_PT: begin
        alu_req.a = OPW'(gu_r);
        alu_req.b = OPW'(aps_r);
      end
      SP_T: begin
        alu_req.op = sdfa_pkg::ALU_DIV;
        alu_req.a  = OPW'(p_r);
        alu_req.b  = OPW'(den_r);
        alu_req.n  = 7'd60;
      end
      SP_VEL: begin
        alu_req.a = OPW'(fmag);
        alu_req.b = OPW'(gain_r);
      end
      default: ;
    endcase
  end

  // result shaping
  logic [OPW-1:0]     res;
  logic [TB-1:0]      idx_c;
  logic [OPW-1:0]     kround;
  logic [32:0]        dsum_add;
  logic [31:0]        dsum_nxt;
  logic               t_apply;
  logic               t_neg;
  logic signed [63:0] fs_ext;
  logic signed [63:0] fs_new;
  logic signed [47:0] fsum_nxt;
  logic [39:0]        vmag;
  logic [31:0]        vel_c;

  always_comb begin
    res = alu_rsp.res;
    // clamp the table index to the last sample
    if (|res[OPW-1:IDX_SHIFT+TB]) idx_c = '1;
    else idx_c = res[IDX_SHIFT+TB-1:IDX_SHIFT];

    kround   = res + (OPW'(1) << 32);
    dsum_add = {1'b0, dsum_r} + 33'(kround[50:33]);
    dsum_nxt = dsum_add[32] ? 32'hFFFF_FFFF : dsum_add[31:0];

    t_apply = (res[58:0] != '0) && (ad_r[ax_r] != '0) && !psz_r;
    t_neg   = (psneg_r == dneg_r[ax_r]);
    fs_ext  = 64'(fsum_r[ax_r]);
    fs_new  = t_neg ? (fs_ext - $signed({5'b0, res[58:0]}))
                    : (fs_ext + $signed({5'b0, res[58:0]}));
    if (fs_new > 64'(FSUM_MAX)) fsum_nxt = FSUM_MAX;
    else if (fs_new < 64'(FSUM_MIN)) fsum_nxt = FSUM_MIN;
    else fsum_nxt = fs_new[47:0];

    vmag = res[55:16];
    if (vneg) begin
      vel_c = (vmag > 40'h0080000000) ? 32'h8000_0000 : 32'(-vmag);
    end else begin
      vel_c = (vmag > 40'h007FFFFFFF) ? 32'h7FFF_FFFF : vmag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      stp_r       <= SP_SQ;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      dsum_r      <= '0;
      fsum_r[0]   <= '0;
      fsum_r[1]   <= '0;
      fsum_r[2]   <= '0;
      fault_r     <= 1'b0;
      inv_h_r     <= 16'd1311;
      kscale_r    <= 32'd87493;
      gscale_r    <= 32'd1750;
      rest_r      <= 24'd196608;
      gain_r      <= 8'd5;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          sdfa_pkg::CFG_INV_H:  inv_h_r  <= cfg_wdata[15:0];
          sdfa_pkg::CFG_KSCALE: kscale_r <= cfg_wdata;
          sdfa_pkg::CFG_GSCALE: gscale_r <= cfg_wdata;
          sdfa_pkg::CFG_REST:   rest_r   <= cfg_wdata[23:0];
          sdfa_pkg::CFG_GAIN:   gain_r   <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      // drop the result once the sink takes it; ST_OUT reloads it itself
      if (out_valid_r && out_ch.ready && (state_r != ST_OUT)) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_FILL: begin
          if (!tbl_busy) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            func_r  <= in_ch.func;
            last_r  <= in_ch.last_pair;
            ad_r[0] <= abs17(dx);
            ad_r[1] <= abs17(dy);
            ad_r[2] <= abs17(dz);
            dneg_r  <= {dz[16], dy[16], dx[16]};
            aps_r   <= aps_full[24:0];
            psneg_r <= ps[26];
            psz_r   <= (ps == '0);
            den_r   <= {in_ch.neighbor_density, 1'b0};
            d2_r    <= '0;
            stp_r   <= SP_SQ;
            ax_r    <= '0;
            // a force pair with zero neighbour density is skipped
            if (in_ch.func && (in_ch.neighbor_density == '0)) begin
              fault_r <= 1'b1;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_TRD:   state_r <= ST_ISSUE;
        ST_WAIT: begin
          if (alu_rsp.done) begin
            unique case (stp_r)
              SP_SQ: begin
                d2_r    <= d2_r + res[33:0];
                state_r <= ST_ISSUE;
                if (ax_r == 2'd2) begin
                  ax_r  <= '0;
                  stp_r <= SP_SQRT;
                end else begin
                  ax_r <= ax_r + 1'b1;
                end
              end
              SP_SQRT: begin
                r_r   <= res[24:0];
                stp_r <= SP_IDX;
                // coincident particles carry no gradient
                if (func_r && (res[24:0] == '0)) state_r <= ST_FIN;
                else state_r <= ST_ISSUE;
              end
              SP_IDX: begin
                idx_r   <= idx_c;
                stp_r   <= func_r ? SP_GRAD : SP_KERN;
                state_r <= ST_TRD;
              end
              SP_KERN: begin
                dsum_r  <= dsum_nxt;
                state_r <= ST_FIN;
              end
              SP_GRAD: begin
                g_r     <= res[49:16];
                ax_r    <= '0;
                stp_r   <= SP_U;
                state_r <= ST_ISSUE;
              end
              SP_U: begin
                u_r     <= (res > OPW'(65536)) ? 17'h10000 : res[16:0];
                stp_r   <= SP_GU;
                state_r <= ST_ISSUE;
              end
              SP_GU: begin
                gu_r    <= res[50:16];
                stp_r   <= SP_PT;
                state_r <= ST_ISSUE;
              end
              SP_PT: begin
                p_r     <= res[59:0];
                stp_r   <= SP_T;
                state_r <= ST_ISSUE;
              end
              SP_T: begin
                if (t_apply) fsum_r[ax_r] <= fsum_nxt;
                if (ax_r == 2'd2) begin
                  state_r <= ST_FIN;
                end else begin
                  ax_r    <= ax_r + 1'b1;
                  stp_r   <= SP_U;
                  state_r <= ST_ISSUE;
                end
              end
              SP_VEL: begin
                vel_r[ax_r] <= vel_c;
                if (ax_r == 2'd2) begin
                  state_r <= ST_OUT;
                end else begin
                  ax_r    <= ax_r + 1'b1;
                  state_r <= ST_ISSUE;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end else begin
            state_r <= ST_WAIT;
          end
        end
        ST_FIN: begin
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (func_r) begin
            ax_r    <= '0;
            stp_r   <= SP_VEL;
            state_r <= ST_ISSUE;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            kind_r      <= func_r;
            flt_o_r     <= fault_r;
            if (func_r) begin
              dens_o_r   <= '0;
              vel_o_r[0] <= vel_r[0];
              vel_o_r[1] <= vel_r[1];
              vel_o_r[2] <= vel_r[2];
            end else begin
              dens_o_r   <= (dsum_r[31:24] != '0) ? 24'hFF_FFFF : dsum_r[23:0];
              vel_o_r[0] <= '0;
              vel_o_r[1] <= '0;
              vel_o_r[2] <= '0;
            end
            dsum_r    <= '0;
            fsum_r[0] <= '0;
            fsum_r[1] <= '0;
            fsum_r[2] <= '0;
            fault_r   <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.density_out = dens_o_r;
  assign out_ch.vel_x       = vel_o_r[0];
  assign out_ch.vel_y       = vel_o_r[1];
  assign out_ch.vel_z       = vel_o_r[2];
  assign out_ch.div_fault   = flt_o_r;

endmodule

// File: hdl/sdfa_alu.sv
// Shared iterative unit: multiply 16 bits a cycle, divide and root one digit a cycle.
module sdfa_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  sdfa_pkg::alu_req_t req,
  output sdfa_pkg::alu_rsp_t rsp
);

  localparam int OPW  = sdfa_pkg::OPW;
  localparam int CNTW = sdfa_pkg::CNTW;

  logic            busy_r;
  logic            done_r;
  logic [1:0]      op_r;
  logic [CNTW-1:0] cnt_r;
  logic [OPW-1:0]  acc_r;
  logic [OPW-1:0]  a_r;
  logic [OPW-1:0]  b_r;
  logic [OPW+1:0]  rem_r;

  logic [OPW-1:0]  mul_pp;
  logic [OPW+1:0]  div_trial;
  logic            div_ge;
  logic [OPW+1:0]  sq_trem;
  logic [OPW+1:0]  sq_trial;
  logic            sq_ge;
  logic            fin;

  always_comb begin
    mul_pp    = a_r * OPW'(b_r[15:0]);
    div_trial = {rem_r[OPW:0], a_r[OPW-1]};
    div_ge    = div_trial >= {2'b00, b_r};
    sq_trem   = {rem_r[OPW-1:0], a_r[OPW-1:OPW-2]};
    sq_trial  = {acc_r, 2'b01};
    sq_ge     = sq_trem >= sq_trial;
    fin       = (op_r == sdfa_pkg::ALU_MUL) ? (b_r == '0) : (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.go) begin
          busy_r <= 1'b1;
          op_r   <= req.op;
          cnt_r  <= req.n;
          acc_r  <= '0;
          rem_r  <= '0;
          b_r    <= req.b;
          unique case (req.op)
            sdfa_pkg::ALU_DIV:  a_r <= req.a << (CNTW'(OPW) - req.n);
            sdfa_pkg::ALU_SQRT: a_r <= req.a << (CNTW'(OPW) - {req.n[CNTW-2:0], 1'b0});
            default:            a_r <= req.a;
          endcase
        end
      end else if (fin) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        unique case (op_r)
          sdfa_pkg::ALU_DIV: begin
            rem_r <= div_ge ? (div_trial - {2'b00, b_r}) : div_trial;
            acc_r <= {acc_r[OPW-2:0], div_ge};
            a_r   <= a_r << 1;
            cnt_r <= cnt_r - 1'b1;
          end
          sdfa_pkg::ALU_SQRT: begin
            rem_r <= sq_ge ? (sq_trem - sq_trial) : sq_trem;
            acc_r <= {acc_r[OPW-2:0], sq_ge};
            a_r   <= a_r << 2;
            cnt_r <= cnt_r - 1'b1;
          end
          default: begin
            acc_r <= acc_r + mul_pp;
            a_r   <= a_r << 16;
            b_r   <= b_r >> 16;
          end
        endcase
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

// File: hdl/sdfa_tables.sv
// Kernel and gradient sample memories, built by a sweep after reset.
module sdfa_tables (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sdfa_pkg::TABLE_BITS-1:0] addr,
  output logic                            busy,
  output sdfa_pkg::tbl_rd_t               rd
);

  localparam int TB  = sdfa_pkg::TABLE_BITS;
  localparam int N   = sdfa_pkg::TABLE_SIZE;
  localparam int SW  = sdfa_pkg::SW;
  localparam int SQW = 2 * TB + 2;
  localparam int KNW = 3 * TB + 4;
  localparam int KSW = KNW + 17;
  localparam int GNW = 2 * TB + 6;
  localparam int GSW = GNW + 16;

  logic [SW-1:0] kmem [N];
  logic [SW-1:0] gmem [N];

  logic          busy_r;
  logic          ph_r;
  logic [TB:0]   fi_r;
  logic [SQW-1:0] sq_r;
  logic [SQW-1:0] msq_r;

  logic [TB-1:0]  idx;
  logic [TB:0]    m;
  logic [KNW-1:0] cube;
  logic [KNW-1:0] mcube;
  logic [KNW-1:0] kn;
  logic [GNW-1:0] gn;
  logic [KSW-1:0] kfull;
  logic [GSW-1:0] gfull;

  always_comb begin
    idx   = fi_r[TB-1:0];
    m     = (TB+1)'(N) - fi_r;
    cube  = KNW'(sq_r) * KNW'(idx);
    mcube = KNW'(msq_r) * KNW'(m);
    if (!idx[TB-1]) begin
      kn = (KNW'(1) << (3 * TB)) + KNW'(6) * cube - ((KNW'(6) * KNW'(sq_r)) << TB);
      gn = ((GNW'(12) * GNW'(idx)) << TB) - GNW'(18) * GNW'(sq_r);
    end else begin
      kn = mcube << 1;
      gn = GNW'(6) * GNW'(msq_r);
    end
    kfull = ((KSW'(kn) << 17) + (KSW'(1) << (3 * TB - 1))) >> (3 * TB);
    gfull = ((GSW'(gn) << 16) + (GSW'(1) << (2 * TB - 1))) >> (2 * TB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      ph_r   <= 1'b0;
      fi_r   <= '0;
    end else if (busy_r) begin
      if (!ph_r) begin
        sq_r  <= SQW'(idx) * SQW'(idx);
        msq_r <= SQW'(m) * SQW'(m);
        ph_r  <= 1'b1;
      end else begin
        ph_r <= 1'b0;
        fi_r <= fi_r + 1'b1;
        if (idx == TB'(N - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && ph_r) begin
      kmem[idx] <= kfull[SW-1:0];
      gmem[idx] <= gfull[SW-1:0];
    end
    rd.ks <= kmem[addr];
    rd.gs <= gmem[addr];
  end

  assign busy = busy_r;

endmodule

// File: hdl/sdfa_checker.sv
// Port-level checks of the accumulator, bound to the top level.
`include "sph_density_force_accumulator_defines.svh"

module sdfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [23:0] out_density,
  input logic [31:0] out_vel_x,
  input logic [31:0] out_vel_y,
  input logic [31:0] out_vel_z
);

  `SDFA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SDFA_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `SDFA_ASSERT_IMP(a_density_no_vel, out_valid && !out_kind, (out_vel_x | out_vel_y | out_vel_z) == '0)
  `SDFA_ASSERT_IMP(a_vel_no_density, out_valid && out_kind, out_density == '0)

endmodule

bind sph_density_force_accumulator sdfa_checker u_sdfa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_density (out_ch.density_out),
  .out_vel_x   (out_ch.vel_x),
  .out_vel_y   (out_ch.vel_y),
  .out_vel_z   (out_ch.vel_z)
);

// File: tb/sph_density_force_accumulator_test.sv
// Self-checking testbench of the SPH density and pressure-force accumulator.
module sph_density_force_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_DENSITY = 1'b0;
  localparam logic FUNC_FORCE   = 1'b1;
  localparam logic [2:0] CFG_SPARE = 3'd5;   // first index past the register file
  localparam int POS_MAX     = 38399;
  localparam int DRAIN_CYCLES = 600;         // longer than one force pair
  localparam int HOLD_CYCLES  = 3000;
  localparam longint FSUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FSUM_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;

  typedef struct {
    logic        func;
    logic [15:0] cx, cy, cz;
    logic [23:0] cd;
    logic [15:0] nx, ny, nz;
    logic [23:0] nd;
    logic        last;
  } pair_t;

  typedef struct {
    logic        kind;
    logic [23:0] density;
    logic [31:0] vx, vy, vz;
    logic        fault;
  } sph_result_t;

  typedef struct {
    pair_t       p;
    bit          typed;   // expected result written into the row
    sph_result_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  sdfa_in_if  in_ch ();
  sdfa_out_if out_ch ();

  sph_density_force_accumulator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers, sums and tables of the block.
  longint unsigned sh_inv_h, sh_kscale, sh_gscale, sh_rest, sh_gain;
  longint unsigned acc_density;
  longint          acc_fx, acc_fy, acc_fz;
  bit              acc_fault;
  logic [17:0]     kern_tab [sdfa_pkg::TABLE_SIZE];
  logic [17:0]     grad_tab [sdfa_pkg::TABLE_SIZE];

  sph_result_t pending_results [$];
  dir_row_t    dir_rows [$];
  int  errors = 0;
  bit  calm = 1'b0;       // no idling on either side
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off

  function automatic void expect_result(input sph_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void build_tables();
    longint unsigned n, n2, n3, kn, gn, m;
    n = sdfa_pkg::TABLE_SIZE;
    n2 = n * n;
    n3 = n2 * n;
    for (longint unsigned i = 0; i < n; i++) begin
      if (2 * i < n) begin
        kn = n3 + 6 * i * i * i - 6 * i * i * n;
        gn = 12 * i * n - 18 * i * i;
      end else begin
        m = n - i;
        kn = 2 * m * m * m;
        gn = 6 * m * m;
      end
      kern_tab[i] = 18'((((kn << 17) + n3 / 2) / n3));
      grad_tab[i] = 18'((((gn << 16) + n2 / 2) / n2));
    end
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint axis_force(longint sum, longint d, longint unsigned r,
                                        longint unsigned g, longint ps,
                                        longint unsigned den);
    longint unsigned ad, aps, u, gu, t;
    longint s;
    ad = (d < 0) ? -d : d;
    aps = (ps < 0) ? -ps : ps;
    u = (ad << 24) / r;
    if (u > 65536) u = 65536;
    gu = (g * u) >> 16;
    t = (aps * gu) / den;
    if (t == 0 || d == 0 || ps == 0) return sum;
    // the term is subtracted where pressure and offset share a sign, else added
    s = ((ps > 0) == (d > 0)) ? sum - longint'(t) : sum + longint'(t);
    if (s > FSUM_MAX) s = FSUM_MAX;
    if (s < FSUM_MIN) s = FSUM_MIN;
    return s;
  endfunction

  function automatic logic [31:0] scale_velocity(longint sum);
    longint unsigned mag, v;
    mag = (sum < 0) ? -sum : sum;
    v = (sh_gain * mag) >> 16;
    if (sum < 0) begin
      if (v > 64'h8000_0000) v = 64'h8000_0000;
      return 32'(-longint'(v));
    end
    if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
    return 32'(v);
  endfunction

  // Fold one pair into the shadow sums; report the result it closes, if any.
  function automatic bit accumulate_pair(input pair_t p, output sph_result_t res);
    longint dx, dy, dz, ps;
    longint unsigned d2, r, idx, term, g, den;
    dx = longint'(p.cx) - longint'(p.nx);
    dy = longint'(p.cy) - longint'(p.ny);
    dz = longint'(p.cz) - longint'(p.nz);
    d2 = dx * dx + dy * dy + dz * dz;
    r = isqrt(d2 << 16);
    idx = (r * sh_inv_h * sdfa_pkg::TABLE_SIZE) >> (sdfa_pkg::POS_FRAC_BITS + 24);
    if (idx > sdfa_pkg::TABLE_SIZE - 1) idx = sdfa_pkg::TABLE_SIZE - 1;
    res = '{default: '0};
    if (p.func == FUNC_DENSITY) begin
      term = (sh_kscale * kern_tab[idx] + (64'd1 << 32)) >> 33;
      acc_density += term;
      if (acc_density > 64'hFFFF_FFFF) acc_density = 64'hFFFF_FFFF;
    end else if (p.nd == 0) begin
      acc_fault = 1'b1;
    end else if (r != 0) begin
      g = (sh_gscale * grad_tab[idx]) >> 16;
      ps = (longint'(p.cd) - longint'(sh_rest)) + (longint'(p.nd) - longint'(sh_rest));
      den = 2 * longint'(p.nd);
      acc_fx = axis_force(acc_fx, dx, r, g, ps, den);
      acc_fy = axis_force(acc_fy, dy, r, g, ps, den);
      acc_fz = axis_force(acc_fz, dz, r, g, ps, den);
    end
    if (!p.last) return 1'b0;
    res.kind = p.func;
    if (p.func == FUNC_DENSITY) begin
      res.density = (acc_density > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(acc_density);
    end else begin
      res.vx = scale_velocity(acc_fx);
      res.vy = scale_velocity(acc_fy);
      res.vz = scale_velocity(acc_fz);
    end
    res.fault = acc_fault;
    acc_density = 0;
    acc_fx = 0;
    acc_fy = 0;
    acc_fz = 0;
    acc_fault = 1'b0;
    return 1'b1;
  endfunction

  // Write one register; only called with the block idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      sdfa_pkg::CFG_INV_H:  sh_inv_h  = value[15:0];
      sdfa_pkg::CFG_KSCALE: sh_kscale = value;
      sdfa_pkg::CFG_GSCALE: sh_gscale = value;
      sdfa_pkg::CFG_REST:   sh_rest   = value[23:0];
      sdfa_pkg::CFG_GAIN:   sh_gain   = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] inv_h, kscale, gscale, rest, gain);
    write_reg(sdfa_pkg::CFG_INV_H, inv_h);
    write_reg(sdfa_pkg::CFG_KSCALE, kscale);
    write_reg(sdfa_pkg::CFG_GSCALE, gscale);
    write_reg(sdfa_pkg::CFG_REST, rest);
    write_reg(sdfa_pkg::CFG_GAIN, gain);
  endtask

  // Offer one pair and hold it until the block takes it.
  task automatic send_pair(input pair_t p, input bit typed, input sph_result_t typed_res);
    sph_result_t res;
    bit emits;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= p.func;
    in_ch.center_x <= p.cx;
    in_ch.center_y <= p.cy;
    in_ch.center_z <= p.cz;
    in_ch.center_density <= p.cd;
    in_ch.neighbor_x <= p.nx;
    in_ch.neighbor_y <= p.ny;
    in_ch.neighbor_z <= p.nz;
    in_ch.neighbor_density <= p.nd;
    in_ch.last_pair <= p.last;
    do @(posedge clk); while (!in_ch.ready);
    emits = accumulate_pair(p, res);
    if (typed) res = typed_res;
    if (emits) expect_result(res);
  endtask

  // Drop valid, let every result arrive, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] near_pos(input logic [15:0] c);
    int v;
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, POS_MAX));
    v = int'(c) + $urandom_range(0, 8000) - 4000;
    if (v < 0) v = 0;
    if (v > POS_MAX) v = POS_MAX;
    return 16'(v);
  endfunction

  function automatic logic [23:0] pick_density();
    int v;
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'($urandom());
      2: return 24'hFF_FFFF;
      default: begin
        v = int'(sh_rest) + $urandom_range(0, 1 << 18) - (1 << 17);
        if (v < 0) v = 0;
        if (v > 24'hFF_FFFF) v = 24'hFF_FFFF;
        return 24'(v);
      end
    endcase
  endfunction

  // Random groups of pairs around one centre particle.
  task automatic random_phase(input int count, input int hold_at);
    pair_t p;
    sph_result_t none;
    int sent, glen;
    logic gfunc;
    bit noise;
    sent = 0;
    none = '{default: '0};
    while (sent < count) begin
      glen = $urandom_range(1, 6);
      gfunc = 1'($urandom_range(0, 1));
      noise = ($urandom_range(0, 9) == 0);
      p.cx = 16'($urandom_range(0, POS_MAX));
      p.cy = 16'($urandom_range(0, POS_MAX));
      p.cz = 16'($urandom_range(0, POS_MAX));
      p.cd = pick_density();
      for (int k = 0; k < glen; k++) begin
        p.func = noise ? 1'($urandom_range(0, 1)) : gfunc;
        p.nx = near_pos(p.cx);
        p.ny = near_pos(p.cy);
        p.nz = near_pos(p.cz);
        if ($urandom_range(0, 15) == 0) begin
          p.nx = p.cx;
          p.ny = p.cy;
          p.nz = p.cz;
        end
        p.nd = pick_density();
        p.last = (k == glen - 1);
        send_pair(p, 1'b0, none);
        sent++;
        if (sent == hold_at) hold_req = 1'b1;
      end
    end
  endtask

  function automatic dir_row_t mk_row(logic func, logic [15:0] cx, cy, cz, logic [23:0] cd,
                                      logic [15:0] nx, ny, nz, logic [23:0] nd,
                                      logic last, bit typed, logic [23:0] dens,
                                      logic fault);
    dir_row_t row;
    row.p = '{func, cx, cy, cz, cd, nx, ny, nz, nd, last};
    row.typed = typed;
    row.r = '{func, dens, 32'd0, 32'd0, 32'd0, fault};
    return row;
  endfunction

  // Receiver: check every result transaction, idle in bursts, one long hold-off.
  initial begin
    sph_result_t want;
    int gap_left, hold_left;
    gap_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d density=%h vel=%h %h %h fault=%0d",
                   $realtime, out_ch.kind, out_ch.density_out, out_ch.vel_x,
                   out_ch.vel_y, out_ch.vel_z, out_ch.div_fault);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, out_ch.kind);
            errors++;
          end
          if (out_ch.density_out !== want.density) begin
            $display("%0t: density_out expected %h actual %h", $realtime, want.density,
                     out_ch.density_out);
            errors++;
          end
          if (out_ch.vel_x !== want.vx) begin
            $display("%0t: vel_x expected %h actual %h", $realtime, want.vx, out_ch.vel_x);
            errors++;
          end
          if (out_ch.vel_y !== want.vy) begin
            $display("%0t: vel_y expected %h actual %h", $realtime, want.vy, out_ch.vel_y);
            errors++;
          end
          if (out_ch.vel_z !== want.vz) begin
            $display("%0t: vel_z expected %h actual %h", $realtime, want.vz, out_ch.vel_z);
            errors++;
          end
          if (out_ch.div_fault !== want.fault) begin
            $display("%0t: div_fault expected %0d actual %0d", $realtime, want.fault,
                     out_ch.div_fault);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        // long stall so the block backs up into its input
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_DENSITY;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.center_z = '0;
    in_ch.center_density = '0;
    in_ch.neighbor_x = '0;
    in_ch.neighbor_y = '0;
    in_ch.neighbor_z = '0;
    in_ch.neighbor_density = '0;
    in_ch.last_pair = 1'b0;
    sh_inv_h = 1311;
    sh_kscale = 87493;
    sh_gscale = 1750;
    sh_rest = 196608;
    sh_gain = 5;
    acc_density = 0;
    acc_fx = 0;
    acc_fy = 0;
    acc_fz = 0;
    acc_fault = 1'b0;
    build_tables();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset settings.
    // coincident density pair: table entry 0, one LSB after rounding
    add_row(mk_row(FUNC_DENSITY, 100, 200, 300, 0, 100, 200, 300, 0, 1, 1, 24'd1, 0));
    // far apart: clamped to the last table entry
    add_row(mk_row(FUNC_DENSITY, 0, 0, 0, 0, POS_MAX, POS_MAX, POS_MAX, 0, 1, 0, 0, 0));
    add_row(mk_row(FUNC_DENSITY, 1000, 1000, 1000, 24'hFFFFFF, 1010, 990, 1000,
                   24'hFFFFFF, 0, 0, 0, 0));
    add_row(mk_row(FUNC_DENSITY, 1000, 1000, 1000, 0, 1500, 1000, 1200, 0, 1, 0, 0, 0));
    // zero neighbour density in force mode: skipped and flagged
    add_row(mk_row(FUNC_FORCE, 5000, 5000, 5000, 300000, 5100, 5000, 5000, 0, 1, 1,
                   0, 1));
    // coincident force pair adds nothing
    add_row(mk_row(FUNC_FORCE, 7000, 7000, 7000, 300000, 7000, 7000, 7000, 250000, 1,
                   1, 0, 0));
    // high pressure, then low pressure, then exactly at rest density
    add_row(mk_row(FUNC_FORCE, 2000, 2000, 2000, 24'hFFFFFF, 2100, 1950, 2010,
                   24'hFFFFFF, 0, 0, 0, 0));
    add_row(mk_row(FUNC_FORCE, 2000, 2000, 2000, 10, 1900, 2050, 1990, 20, 0, 0, 0, 0));
    add_row(mk_row(FUNC_FORCE, 2000, 2000, 2000, 196608, 2200, 2000, 1800, 196608, 1,
                   0, 0, 0));
    // mixed group: density sum is discarded by a force last pair, and the reverse
    add_row(mk_row(FUNC_DENSITY, 3000, 3000, 3000, 0, 3010, 3000, 3000, 0, 0, 0, 0, 0));
    add_row(mk_row(FUNC_FORCE, 3000, 3000, 3000, 400000, 3050, 3020, 2990, 0, 0, 0, 0,
                   0));
    add_row(mk_row(FUNC_FORCE, 3000, 3000, 3000, 400000, 3050, 3020, 2990, 350000, 1,
                   0, 0, 0));
    add_row(mk_row(FUNC_FORCE, 3000, 3000, 3000, 400000, 2950, 3100, 3000, 350000, 0,
                   0, 0, 0));
    add_row(mk_row(FUNC_DENSITY, 3000, 3000, 3000, 0, 3000, 3040, 3000, 0, 1, 0, 0, 0));
    add_row(mk_row(FUNC_FORCE, POS_MAX, 0, POS_MAX, 24'hFFFFFF, 0, POS_MAX, 0, 1, 1, 0,
                   0, 0));
    foreach (dir_rows[i]) send_pair(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].r);
    drain();

    // Random settings; the receiver stalls long part way through.
    write_all($urandom(), $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 14),
              $urandom(), $urandom());
    write_reg(CFG_SPARE, $urandom());
    random_phase(110, 40);
    drain();

    // Top extremes: short h, largest scales, rest and gain.
    write_all(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0000_00FF);
    write_reg(CFG_SPARE + 3'd2, 32'hFFFF_FFFF);
    random_phase(110, -1);
    drain();

    // Bottom extremes: zero 1/h pins table entry 0, zero scales and gain.
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(60, -1);
    drain();
    write_all(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1);
    random_phase(60, -1);
    drain();

    write_all(1311 + $urandom_range(0, 4000), $urandom_range(0, 1 << 24),
              $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 20), $urandom_range(0, 255));
    random_phase(110, -1);
    drain();

    // Back to reset values, with no idling for the final stretch.
    write_all(1311, 87493, 1750, 196608, 5);
    calm = 1'b1;
    random_phase(100, -1);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
